// ----- hdl/tspc_pkg.sv -----
// Shared types and constants for the train speed PI controller.
// Used by tspc_ctrl, tspc_datapath and train_speed_pi_controller_core.
`default_nettype none

package tspc_pkg;

    // Event codes carried in the op field
    typedef enum logic [1:0] {
        OP_RAISE  = 2'd0,
        OP_LOWER  = 2'd1,
        OP_EBRAKE = 2'd2,
        OP_SBRAKE = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic CFG_PROP_GAIN  = 1'b0;
    localparam logic CFG_INTEG_GAIN = 1'b1;

    // 1.60934 km/h per mph in Q8.8
    localparam int unsigned KPH_PER_MPH_Q8 = 412;
    // integration period in seconds, Q8.8
    localparam logic [15:0] PERIOD_Q8 = 16'd256;
    localparam int unsigned MAX_POWER_W = 120000;

    localparam logic signed [47:0] INTEG_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] INTEG_MIN = {1'b1, {47{1'b0}}};
    localparam logic signed [63:0] TERM_MAX  = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] TERM_MIN  = -64'sh4000_0000_0000_0000;

    // Input transaction payload
    typedef struct packed {
        t_op         op;
        logic [15:0] current_speed;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic signed [31:0] commanded_power;
        logic [7:0]         setpoint_speed;
        logic               emergency_brake;
        logic               service_brake;
        logic               power_clamped;
    } t_out;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERROR,
        ST_INTEG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic calc_err;
        logic calc_integ;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip_power;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/tspc_ctrl.sv -----
// Sequencer for the PI controller: steps one transaction through the datapath.
// Depends on tspc_pkg.
`default_nettype none

module tspc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  tspc_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output tspc_pkg::t_cmd   o_cmd
);

    tspc_pkg::t_state r_state;
    tspc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tspc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tspc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.skip_power ? tspc_pkg::ST_COMMIT : tspc_pkg::ST_ERROR;
                end
            end
            tspc_pkg::ST_ERROR:  n_state = tspc_pkg::ST_INTEG;
            tspc_pkg::ST_INTEG:  n_state = tspc_pkg::ST_MUL_LO;
            tspc_pkg::ST_MUL_LO: n_state = tspc_pkg::ST_MUL_HI;
            tspc_pkg::ST_MUL_HI: n_state = tspc_pkg::ST_SUM;
            tspc_pkg::ST_SUM:    n_state = tspc_pkg::ST_COMMIT;
            tspc_pkg::ST_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = tspc_pkg::ST_IDLE;
                end
            end
            default: n_state = tspc_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tspc_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            tspc_pkg::ST_ERROR:  o_cmd.calc_err   = 1'b1;
            tspc_pkg::ST_INTEG:  o_cmd.calc_integ = 1'b1;
            tspc_pkg::ST_MUL_LO: o_cmd.mul_lo     = 1'b1;
            tspc_pkg::ST_MUL_HI: o_cmd.mul_hi     = 1'b1;
            tspc_pkg::ST_SUM:    o_cmd.sum        = 1'b1;
            tspc_pkg::ST_COMMIT: o_cmd.commit     = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/tspc_datapath.sv -----
// Datapath for the PI controller: setpoint, brake flags, error, integral,
// split integral-gain product and the output register. Depends on tspc_pkg.
`default_nettype none

module tspc_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  tspc_pkg::t_cmd   i_cmd,
    input  tspc_pkg::t_in    i_in,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [15:0]       i_cfg_data,
    input  wire              i_out_ready,
    output tspc_pkg::t_stat  o_stat,
    output logic             o_out_valid,
    output tspc_pkg::t_out   o_out
);

    // gains
    logic [15:0] r_kp;
    logic [15:0] r_ki;

    // persistent state
    logic [7:0]         r_setpoint;
    logic               r_ebrake;
    logic               r_sbrake;
    logic signed [17:0] r_prev;
    logic signed [47:0] r_integ;
    logic signed [31:0] r_last_power;
    logic               r_last_clamped;

    // per-transaction working registers
    logic [15:0]        r_speed;
    logic               r_do_power;
    logic signed [17:0] r_err;
    logic signed [47:0] r_u;
    logic signed [34:0] r_pterm;
    logic [39:0]        r_plo;
    logic signed [40:0] r_phi;
    logic signed [63:0] r_a;

    logic               r_out_valid;
    tspc_pkg::t_out     r_out;

    // error in km/h Q.8
    logic [24:0]        cur_full;
    logic [16:0]        sp_kph;
    logic signed [17:0] err_next;
    // trapezoid step
    logic signed [18:0] err_sum;
    logic signed [35:0] integ_inc;
    logic signed [48:0] u_wide;
    logic signed [47:0] u_sat;
    logic signed [34:0] pterm_next;
    // products
    logic [39:0]        plo_next;
    logic signed [40:0] phi_next;
    logic signed [63:0] a_full;
    logic signed [63:0] a_clamp;
    // power
    logic signed [63:0] pwr_sum;
    logic signed [46:0] pwr_floor;
    logic               clamp_hi;
    logic signed [31:0] pwr_final;
    logic               out_free;

    assign cur_full   = 25'({9'd0, r_speed} * 25'(tspc_pkg::KPH_PER_MPH_Q8)) + 25'd128;
    assign sp_kph     = 17'(r_setpoint) * 17'(tspc_pkg::KPH_PER_MPH_Q8);
    assign err_next   = $signed({1'b0, sp_kph}) - $signed({1'b0, cur_full[24:8]});

    assign err_sum    = 19'(r_err) + 19'(r_prev);
    assign integ_inc  = 36'(err_sum * $signed({1'b0, tspc_pkg::PERIOD_Q8}));
    assign u_wide     = 49'(r_integ) + 49'(integ_inc);
    assign pterm_next = 35'($signed({1'b0, r_kp}) * r_err);

    // saturate integral to 48-bit signed
    always_comb begin
        if (u_wide[48] != u_wide[47]) begin
            u_sat = u_wide[48] ? tspc_pkg::INTEG_MIN : tspc_pkg::INTEG_MAX;
        end else begin
            u_sat = u_wide[47:0];
        end
    end

    // ki*u split into low unsigned and high signed halves of u
    assign plo_next = 40'(r_ki) * 40'(r_u[23:0]);
    assign phi_next = 41'($signed({1'b0, r_ki}) * $signed(r_u[47:24]));
    assign a_full   = $signed({r_phi[39:0], 24'd0}) + $signed({24'd0, r_plo});

    always_comb begin
        if (a_full > tspc_pkg::TERM_MAX) begin
            a_clamp = tspc_pkg::TERM_MAX;
        end else if (a_full < tspc_pkg::TERM_MIN) begin
            a_clamp = tspc_pkg::TERM_MIN;
        end else begin
            a_clamp = a_full;
        end
    end

    // power = floor((ki*u + kp*e*512) / 2^17), clamped
    assign pwr_sum   = r_a + (64'(r_pterm) <<< 9);
    assign pwr_floor = pwr_sum[63:17];
    assign clamp_hi  = pwr_floor > $signed(47'(tspc_pkg::MAX_POWER_W));

    always_comb begin
        if (clamp_hi) begin
            pwr_final = 32'(tspc_pkg::MAX_POWER_W);
        end else if (pwr_floor < -47'sd2147483648) begin
            pwr_final = 32'sh8000_0000;
        end else begin
            pwr_final = pwr_floor[31:0];
        end
    end

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_stat.out_free = out_free;
    assign o_stat.skip_power = (i_in.op == tspc_pkg::OP_LOWER) && (r_setpoint == 8'd0);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tspc_pkg::CFG_PROP_GAIN) begin
                r_kp <= i_cfg_data;
            end else begin
                r_ki <= i_cfg_data;
            end
        end
    end

    // setpoint, brakes and committed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint     <= '0;
            r_ebrake       <= 1'b0;
            r_sbrake       <= 1'b0;
            r_prev         <= '0;
            r_integ        <= '0;
            r_last_power   <= '0;
            r_last_clamped <= 1'b0;
            r_do_power     <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                case (i_in.op)
                    tspc_pkg::OP_RAISE: begin
                        if (r_setpoint != 8'hFF) begin
                            r_setpoint <= r_setpoint + 8'd1;
                        end
                        r_do_power <= 1'b1;
                    end
                    tspc_pkg::OP_LOWER: begin
                        if (r_setpoint != 8'd0) begin
                            r_setpoint <= r_setpoint - 8'd1;
                        end
                        r_do_power <= (r_setpoint != 8'd0);
                    end
                    tspc_pkg::OP_EBRAKE: begin
                        r_ebrake   <= 1'b1;
                        r_setpoint <= '0;
                        r_do_power <= 1'b1;
                    end
                    tspc_pkg::OP_SBRAKE: begin
                        r_sbrake   <= 1'b1;
                        r_setpoint <= '0;
                        r_do_power <= 1'b1;
                    end
                    default: r_do_power <= 1'b0;
                endcase
            end
            if (i_cmd.commit && r_do_power) begin
                r_prev         <= r_err;
                r_last_power   <= pwr_final;
                r_last_clamped <= clamp_hi;
                // anti-windup: keep old integral when clamped
                if (!clamp_hi) begin
                    r_integ <= r_u;
                end
            end
        end
    end

    // working registers, one step per command
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept)     r_speed <= i_in.current_speed;
        if (i_cmd.calc_err)   r_err   <= err_next;
        if (i_cmd.calc_integ) begin
            r_u     <= u_sat;
            r_pterm <= pterm_next;
        end
        if (i_cmd.mul_lo)     r_plo   <= plo_next;
        if (i_cmd.mul_hi)     r_phi   <= phi_next;
        if (i_cmd.sum)        r_a     <= a_clamp;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.commanded_power <= r_do_power ? pwr_final : r_last_power;
            r_out.power_clamped   <= r_do_power ? clamp_hi  : r_last_clamped;
            r_out.setpoint_speed  <= r_setpoint;
            r_out.emergency_brake <= r_ebrake;
            r_out.service_brake   <= r_sbrake;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- hdl/train_speed_pi_controller_core.sv -----
// Train speed PI controller, top level: sequencer plus datapath.
// Depends on tspc_pkg, tspc_ctrl and tspc_datapath.
//
// Each input transaction (raise/lower setpoint, emergency or service brake,
// with measured speed in mph Q8.8) yields exactly one output transaction
// holding the drive power, setpoint and brake/clamp flags. An event that
// recomputes power passes from the accept state through five datapath steps
// (error, trapezoid integral, two halves of the 16x48 integral-gain product,
// sum and clamp) to a commit state that loads the output register. Lowering a
// zero setpoint goes from accept straight to commit and repeats the last
// power. Commit waits while a prior result is unread; the next input is
// accepted while a committed result sits in the output register. Gains must be
// written through the config port only while idle; the block does not enforce it.
`default_nettype none

module train_speed_pi_controller_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  tspc_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output tspc_pkg::t_out  o_out,
    input  wire             i_cfg_we,
    input  wire             i_cfg_idx,
    input  wire [15:0]      i_cfg_data
);

    tspc_pkg::t_cmd  cmd;
    tspc_pkg::t_stat stat;

    tspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tspc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ----- tb/train_speed_pi_controller_core_tb.sv -----
// Testbench for train_speed_pi_controller_core: directed and random speed events
// checked against a cycle-free PI power predictor. Depends on tspc_pkg and the
// core RTL; self-contained otherwise.
`default_nettype none

module train_speed_pi_controller_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Controller constants, kept independent of the design's own copies
    localparam longint KMH_PER_MPH_Q8 = 412;
    localparam longint PERIOD_STEP    = 256;
    localparam longint POWER_LIMIT    = 120000;
    localparam longint INTEG_HI       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO       = -INTEG_HI - 1;
    localparam longint GAIN_TERM_LIM  = 64'sh4000_0000_0000_0000;
    localparam longint POWER_FLOOR    = -64'sd2147483648;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 1000;

    logic           i_clk;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    tspc_pkg::t_in  in_item   = '0;
    logic           out_ready = 1'b0;
    logic           cfg_we    = 1'b0;
    logic           cfg_idx   = 1'b0;
    logic [15:0]    cfg_data  = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    tspc_pkg::t_out o_out;

    train_speed_pi_controller_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state, mirrors the controller after every accepted event
    logic [15:0] kp_gain      = '0;
    logic [15:0] ki_gain      = '0;
    logic [7:0]  setpoint_mph = '0;
    longint      last_error   = 0;
    longint      integ_sum    = 0;
    logic        ebrake_set   = 1'b0;
    logic        sbrake_set   = 1'b0;
    logic [31:0] held_power   = '0;
    logic        held_clamp   = 1'b0;

    tspc_pkg::t_out pending_results[$];
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    bit   steady_input = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance predictor by one event and return the expected output transaction
    task automatic predict_power_event(input tspc_pkg::t_op op, input logic [15:0] speed,
                                       output tspc_pkg::t_out res);
        bit     recompute;
        longint sp_kmh, cur_kmh, err, integ_next, ki_term, kp_term, power;
        recompute = 1'b1;
        case (op)
            tspc_pkg::OP_RAISE: begin
                if (setpoint_mph != 8'd255) setpoint_mph = setpoint_mph + 8'd1;
            end
            tspc_pkg::OP_LOWER: begin
                if (setpoint_mph != 8'd0) setpoint_mph = setpoint_mph - 8'd1;
                else recompute = 1'b0;
            end
            tspc_pkg::OP_EBRAKE: begin
                ebrake_set   = 1'b1;
                setpoint_mph = 8'd0;
            end
            default: begin
                sbrake_set   = 1'b1;
                setpoint_mph = 8'd0;
            end
        endcase
        if (recompute) begin
            sp_kmh     = longint'(setpoint_mph) * KMH_PER_MPH_Q8;
            cur_kmh    = (longint'(speed) * KMH_PER_MPH_Q8 + 128) >>> 8;
            err        = sp_kmh - cur_kmh;
            integ_next = integ_sum + PERIOD_STEP * (err + last_error);
            if (integ_next > INTEG_HI) integ_next = INTEG_HI;
            if (integ_next < INTEG_LO) integ_next = INTEG_LO;
            ki_term = longint'(ki_gain) * integ_next;
            if (ki_term > GAIN_TERM_LIM) ki_term = GAIN_TERM_LIM;
            if (ki_term < -GAIN_TERM_LIM) ki_term = -GAIN_TERM_LIM;
            kp_term = longint'(kp_gain) * err * 512;
            // arithmetic shift of a signed value rounds toward minus infinity
            power      = (ki_term + kp_term) >>> 17;
            last_error = err;
            // anti-windup: integral frozen while clamped
            if (power > POWER_LIMIT) begin
                power      = POWER_LIMIT;
                held_clamp = 1'b1;
            end else begin
                integ_sum  = integ_next;
                held_clamp = 1'b0;
            end
            if (power < POWER_FLOOR) power = POWER_FLOOR;
            held_power = power[31:0];
        end
        res.commanded_power = held_power;
        res.setpoint_speed  = setpoint_mph;
        res.emergency_brake = ebrake_set;
        res.service_brake   = sbrake_set;
        res.power_clamped   = held_clamp;
    endtask

    // Mostly short gaps, a few long ones; none in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // One input transaction; expectation queued at acceptance
    task automatic send_event(input tspc_pkg::t_op op, input logic [15:0] speed);
        int             gap;
        tspc_pkg::t_out res;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid              <= 1'b1;
        in_item.op            <= op;
        in_item.current_speed <= speed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_power_event(op, speed, res);
        pending_results.push_back(res);
    endtask

    // Drain all outstanding results, then let the core go idle
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both gains back to back; only called while idle
    task automatic write_gains(input logic [15:0] kp, input logic [15:0] ki);
        cfg_we   <= 1'b1;
        cfg_idx  <= tspc_pkg::CFG_PROP_GAIN;
        cfg_data <= kp;
        @(posedge i_clk);
        cfg_idx  <= tspc_pkg::CFG_INTEG_GAIN;
        cfg_data <= ki;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        kp_gain = kp;
        ki_gain = ki;
    endtask

    // Field extremes, every op, lower at zero, brakes, raise under brake, clamp
    task automatic test_directed();
        write_gains(16'd300, 16'd40);
        send_event(tspc_pkg::OP_LOWER, 16'h0000);
        send_event(tspc_pkg::OP_RAISE, 16'h0000);
        send_event(tspc_pkg::OP_RAISE, 16'hFFFF);
        send_event(tspc_pkg::OP_RAISE, 16'h0100);
        send_event(tspc_pkg::OP_LOWER, 16'h0080);
        send_event(tspc_pkg::OP_LOWER, 16'h0000);
        send_event(tspc_pkg::OP_LOWER, 16'h0000);
        send_event(tspc_pkg::OP_LOWER, 16'hFFFF);
        send_event(tspc_pkg::OP_EBRAKE, 16'h1234);
        send_event(tspc_pkg::OP_RAISE, 16'h0000);
        send_event(tspc_pkg::OP_SBRAKE, 16'hFFFF);
        send_event(tspc_pkg::OP_LOWER, 16'h5555);
        settle();
        write_gains(16'hFFFF, 16'hFFFF);
        send_event(tspc_pkg::OP_RAISE, 16'h0000);
        send_event(tspc_pkg::OP_RAISE, 16'h0000);
        send_event(tspc_pkg::OP_RAISE, 16'hAAAA);
        send_event(tspc_pkg::OP_LOWER, 16'h0000);
        send_event(tspc_pkg::OP_LOWER, 16'h0000);
        send_event(tspc_pkg::OP_LOWER, 16'h0000);
        send_event(tspc_pkg::OP_LOWER, 16'h0000);
        settle();
    endtask

    // Climb past the 255 mph setpoint ceiling, then step back down
    task automatic test_setpoint_limit();
        int k;
        write_gains(16'($urandom_range(1, 65535)), 16'd0);
        for (k = 0; k < 262; k++) send_event(tspc_pkg::OP_RAISE, 16'($urandom));
        for (k = 0; k < 10; k++) send_event(tspc_pkg::OP_LOWER, 16'($urandom));
        settle();
    endtask

    // Setpoint tracking with speed near setpoint, brakes, and random noise
    task automatic test_random_traffic(input logic [15:0] kp, input logic [15:0] ki,
                                       input int count);
        int            k, r, spd;
        tspc_pkg::t_op op;
        logic [15:0]   speed;
        write_gains(kp, ki);
        for (k = 0; k < count; k++) begin
            if (k % 64 == 0) steady_input = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                op    = tspc_pkg::t_op'($urandom_range(0, 3));
                speed = 16'($urandom);
            end else begin
                if (r < 14) op = $urandom_range(0, 1) ? tspc_pkg::OP_EBRAKE
                                                      : tspc_pkg::OP_SBRAKE;
                else if (r < 58) op = tspc_pkg::OP_RAISE;
                else op = tspc_pkg::OP_LOWER;
                spd = int'(setpoint_mph) * 256 + $urandom_range(0, 4000) - 2000;
                if (spd < 0) spd = 0;
                if (spd > 65535) spd = 65535;
                speed = 16'(spd);
            end
            send_event(op, speed);
        end
        steady_input = 1'b0;
        settle();
    endtask

    // Drive the integral deeply negative until power saturates at the low limit
    task automatic test_negative_saturation();
        int k;
        write_gains(16'hFFFF, 16'hFFFF);
        for (k = 0; k < 400; k++)
            send_event((k % 2) ? tspc_pkg::OP_EBRAKE : tspc_pkg::OP_SBRAKE, 16'hFFFF);
        for (k = 0; k < 6; k++) send_event(tspc_pkg::OP_RAISE, 16'hFFFF);
        for (k = 0; k < 8; k++) send_event(tspc_pkg::OP_LOWER, 16'h0000);
        settle();
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checker: compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        tspc_pkg::t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, power %0d", $time,
                         o_out.commanded_power);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("commanded_power", longint'(want.commanded_power),
                              longint'(o_out.commanded_power));
                compare_field("setpoint_speed", want.setpoint_speed, o_out.setpoint_speed);
                compare_field("emergency_brake", want.emergency_brake,
                              o_out.emergency_brake);
                compare_field("service_brake", want.service_brake, o_out.service_brake);
                compare_field("power_clamped", want.power_clamped, o_out.power_clamped);
            end
        end
    end

    // Output side backpressure: random stalls with occasional free-running stretches
    initial begin : out_side
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < 10) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL train_speed_pi_controller_core");
                $finish;
            end
        end
    end

    initial begin : main_seq
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_setpoint_limit();
        test_random_traffic(16'd0, 16'd0, 260);
        test_random_traffic(16'($urandom), 16'($urandom), 260);
        test_random_traffic(16'hFFFF, 16'hFFFF, 260);
        test_random_traffic(16'($urandom_range(1, 50)), 16'($urandom_range(1, 5)), 260);
        test_negative_saturation();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS train_speed_pi_controller_core");
        end else begin
            $display("FAIL train_speed_pi_controller_core");
        end
        $finish;
    end

endmodule

`default_nettype wire
